>>> sv/dcsp_pkg.sv
`timescale 1ns / 1ps
// Package for the drive command to servo pulse block.
// Holds item codes, register indexes, the configuration struct and the
// command struct for the shared arithmetic unit. No dependencies.
package dcsp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int PULSE_W     = 12;
   localparam int LIMIT_W     = 15;
   localparam int VALUE_W     = 16;
   localparam int SPAN_W      = 13;
   localparam int PROD_W      = 29;
   localparam int NUM_W       = 30;
   localparam int AGE_W       = 8;
   localparam int DIV_STEPS   = 12;
   localparam int DIV_CNT_W   = 4;

   // Item kinds
   typedef enum logic [1:0] {
      FUNC_DRIVE = 2'd0,
      FUNC_STOP  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   // Result causes
   typedef enum logic [1:0] {
      CAUSE_MAPPED  = 2'd0,
      CAUSE_STOP    = 2'd1,
      CAUSE_TIMEOUT = 2'd2
   } cause_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_STEER_LIMIT     = 3'd0,
      REG_SPEED_LIMIT     = 3'd1,
      REG_STEER_LEFT_US   = 3'd2,
      REG_STEER_CENTER_US = 3'd3,
      REG_STEER_RIGHT_US  = 3'd4,
      REG_THR_REVERSE_US  = 3'd5,
      REG_THR_NEUTRAL_US  = 3'd6,
      REG_THR_FORWARD_US  = 3'd7
   } reg_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_MUL0,
      ST_MUL1,
      ST_DIV,
      ST_STORE,
      ST_DONE
   } state_type;

   // Shared unit operations
   typedef enum logic [1:0] {
      ARITH_HOLD,
      ARITH_MUL_LOAD,
      ARITH_MUL_ACC,
      ARITH_DIV_STEP
   } arith_op_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] steer_limit;
      logic [LIMIT_W-1:0] speed_limit;
      logic [PULSE_W-1:0] steer_left_us;
      logic [PULSE_W-1:0] steer_center_us;
      logic [PULSE_W-1:0] steer_right_us;
      logic [PULSE_W-1:0] thr_reverse_us;
      logic [PULSE_W-1:0] thr_neutral_us;
      logic [PULSE_W-1:0] thr_forward_us;
   } cfg_type;

   typedef struct packed {
      arith_op_type              op;
      logic signed [VALUE_W-1:0] mul_a;
      logic signed [SPAN_W-1:0]  mul_b;
      logic [LIMIT_W-1:0]        divisor;
   } arith_cmd_type;

endpackage

>>> sv/dcsp_req_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready handshake with the command item payload.
// Depends on dcsp_pkg for field widths.
interface dcsp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            func;
   logic signed [dcsp_pkg::VALUE_W-1:0]   steer_angle;
   logic signed [dcsp_pkg::VALUE_W-1:0]   speed_req;
   logic                                  stop_level;

   modport source (output valid, func, steer_angle, speed_req, stop_level, input ready);
   modport sink   (input valid, func, steer_angle, speed_req, stop_level, output ready);
endinterface

>>> sv/dcsp_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the pulse item payload.
// Depends on dcsp_pkg for field widths.
interface dcsp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dcsp_pkg::PULSE_W-1:0]      steer_pulse_us;
   logic [dcsp_pkg::PULSE_W-1:0]      throttle_pulse_us;
   logic [1:0]                        cause;

   modport source (output valid, steer_pulse_us, throttle_pulse_us, cause, input ready);
   modport sink   (input valid, steer_pulse_us, throttle_pulse_us, cause, output ready);
endinterface

>>> sv/drive_command_to_servo_pulse.sv
`timescale 1ns / 1ps
// Drive command to servo pulse mapper with watchdog (top level).
// Sequence: a stop or timeout result is registered in the cycle after accept; a
// mapped drive command runs the shared multiply/divide unit once per channel
// (clamp, two multiplies, 12 divide steps, store), then loads the result
// register once it frees.
// Throughput: one item at a time; ready returns once the result register frees.
// Reset (synchronous): clears stop latch, command age, result valid; registers reload.
module drive_command_to_servo_pulse #(
   parameter int TIMEOUT_TICKS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   dcsp_req_if.sink                          req_chan,
   dcsp_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [dcsp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dcsp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dcsp_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   arith_cmd_type       cmd;
   logic [PULSE_W-1:0]  quotient;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_STEER_LIMIT:     cfg_in.steer_limit     = csr_wdata;
            REG_SPEED_LIMIT:     cfg_in.speed_limit     = csr_wdata;
            REG_STEER_LEFT_US:   cfg_in.steer_left_us   = csr_wdata[PULSE_W-1:0];
            REG_STEER_CENTER_US: cfg_in.steer_center_us = csr_wdata[PULSE_W-1:0];
            REG_STEER_RIGHT_US:  cfg_in.steer_right_us  = csr_wdata[PULSE_W-1:0];
            REG_THR_REVERSE_US:  cfg_in.thr_reverse_us  = csr_wdata[PULSE_W-1:0];
            REG_THR_NEUTRAL_US:  cfg_in.thr_neutral_us  = csr_wdata[PULSE_W-1:0];
            REG_THR_FORWARD_US:  cfg_in.thr_forward_us  = csr_wdata[PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steer_limit     <= LIMIT_W'(1843);
         cfg_ff.speed_limit     <= LIMIT_W'(4096);
         cfg_ff.steer_left_us   <= PULSE_W'(1100);
         cfg_ff.steer_center_us <= PULSE_W'(1500);
         cfg_ff.steer_right_us  <= PULSE_W'(1900);
         cfg_ff.thr_reverse_us  <= PULSE_W'(1300);
         cfg_ff.thr_neutral_us  <= PULSE_W'(1500);
         cfg_ff.thr_forward_us  <= PULSE_W'(1700);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcsp_ctrl #(
      .TIMEOUT_TICKS (TIMEOUT_TICKS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .quotient (quotient)
   );

   dcsp_arith u_arith (
      .clock    (clock),
      .cmd      (cmd),
      .quotient (quotient)
   );

endmodule

>>> sv/dcsp_arith.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: signed multiply with accumulate, then a restoring
// divider that retires one quotient bit per step. Depends on dcsp_pkg.
module dcsp_arith (
   input  logic                          clock,
   input  dcsp_pkg::arith_cmd_type       cmd,
   output logic [dcsp_pkg::PULSE_W-1:0]  quotient
);
   import dcsp_pkg::*;

   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic signed [NUM_W-1:0]    num;
   logic [NUM_W-1:0]           num_pos;
   logic [LIMIT_W-1:0]         rem_ff, rem_in;
   logic [DIV_STEPS-1:0]       low_ff, low_in;
   logic [LIMIT_W:0]           rem_shift;
   logic signed [LIMIT_W+1:0]  diff;

   // Multiply the selected operands
   assign prod = PROD_W'(cmd.mul_a) * PROD_W'(cmd.mul_b);

   // Form the dividend and clip it at zero
   assign num     = NUM_W'(acc_ff) + NUM_W'(prod);
   assign num_pos = num[NUM_W-1] ? '0 : num;

   // Trial subtract for one divide step
   assign rem_shift = {rem_ff, low_ff[DIV_STEPS-1]};
   assign diff      = $signed({1'b0, rem_shift}) - $signed({2'b00, cmd.divisor});

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      case (cmd.op)
         ARITH_MUL_LOAD: begin
            acc_in = prod;
         end
         ARITH_MUL_ACC: begin
            rem_in = num_pos[DIV_STEPS +: LIMIT_W];
            low_in = num_pos[DIV_STEPS-1:0];
         end
         ARITH_DIV_STEP: begin
            if (diff[LIMIT_W+1]) begin
               rem_in = rem_shift[LIMIT_W-1:0];
               low_in = {low_ff[DIV_STEPS-2:0], 1'b0};
            end else begin
               rem_in = diff[LIMIT_W-1:0];
               low_in = {low_ff[DIV_STEPS-2:0], 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign quotient = low_ff;

endmodule

>>> sv/dcsp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: decodes items, keeps the stop latch and command age, drives the
// shared arithmetic unit and holds the result register. Depends on dcsp_pkg.
module dcsp_ctrl #(
   parameter int TIMEOUT_TICKS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcsp_pkg::cfg_type             cfg,
   dcsp_req_if.sink                      req_chan,
   dcsp_rsp_if.source                    rsp_chan,
   output dcsp_pkg::arith_cmd_type       cmd,
   input  logic [dcsp_pkg::PULSE_W-1:0]  quotient
);
   import dcsp_pkg::*;

   state_type                  state_ff, state_in;
   logic                       chan_ff, chan_in;
   logic [DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic                       stop_ff, stop_in;
   logic [AGE_W-1:0]           age_ff, age_in;
   logic signed [VALUE_W-1:0]  angle_ff, angle_in;
   logic signed [VALUE_W-1:0]  speed_ff, speed_in;
   logic signed [VALUE_W-1:0]  vc_ff, vc_in;
   logic signed [SPAN_W-1:0]   span_ff, span_in;
   logic [PULSE_W-1:0]         steer_ff, steer_in;
   logic [PULSE_W-1:0]         thr_ff, thr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]         rsp_steer_ff, rsp_steer_in;
   logic [PULSE_W-1:0]         rsp_thr_ff, rsp_thr_in;
   logic [1:0]                 rsp_cause_ff, rsp_cause_in;

   logic                       out_free;
   logic                       accept;
   logic                       result_now;
   logic [AGE_W-1:0]           age_next;
   logic [LIMIT_W-1:0]         sel_m;
   logic [PULSE_W-1:0]         sel_lo, sel_mid, sel_hi;
   logic signed [VALUE_W-1:0]  sel_v;
   logic signed [VALUE_W:0]    lim_pos, lim_neg, v_ext;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   // Saturating age after a tick
   assign age_next = (age_ff == '1) ? age_ff : age_ff + AGE_W'(1);

   // Select the active channel's limit, endpoints and value
   always_comb begin
      if (chan_ff) begin
         sel_m   = cfg.speed_limit;
         sel_lo  = cfg.thr_reverse_us;
         sel_mid = cfg.thr_neutral_us;
         sel_hi  = cfg.thr_forward_us;
         sel_v   = speed_ff;
      end else begin
         sel_m   = cfg.steer_limit;
         sel_lo  = cfg.steer_left_us;
         sel_mid = cfg.steer_center_us;
         sel_hi  = cfg.steer_right_us;
         sel_v   = angle_ff;
      end
   end

   assign lim_pos = $signed({2'b00, sel_m});
   assign lim_neg = -lim_pos;
   assign v_ext   = (VALUE_W+1)'(sel_v);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.func == FUNC_DRIVE && !stop_ff) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (sel_m != '0) begin
               state_in = ST_MUL0;
            end else if (chan_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: state_in = chan_ff ? ST_DONE : ST_CLAMP;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      chan_in      = chan_ff;
      cnt_in       = cnt_ff;
      stop_in      = stop_ff;
      age_in       = age_ff;
      angle_in     = angle_ff;
      speed_in     = speed_ff;
      vc_in        = vc_ff;
      span_in      = span_ff;
      steer_in     = steer_ff;
      thr_in       = thr_ff;
      rsp_steer_in = rsp_steer_ff;
      rsp_thr_in   = rsp_thr_ff;
      rsp_cause_in = rsp_cause_ff;
      result_now   = 1'b0;
      cmd.op       = ARITH_HOLD;
      cmd.mul_a    = vc_ff;
      cmd.mul_b    = span_ff;
      cmd.divisor  = sel_m;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               angle_in = req_chan.steer_angle;
               speed_in = req_chan.speed_req;
               chan_in  = 1'b0;
               case (req_chan.func)
                  FUNC_DRIVE: begin
                     age_in = '0;
                     if (stop_ff) begin
                        result_now   = 1'b1;
                        rsp_cause_in = CAUSE_STOP;
                     end
                  end
                  FUNC_STOP: begin
                     stop_in = req_chan.stop_level;
                     if (req_chan.stop_level) begin
                        result_now   = 1'b1;
                        rsp_cause_in = CAUSE_STOP;
                     end
                  end
                  FUNC_TICK: begin
                     age_in = age_next;
                     if (age_next > AGE_W'(TIMEOUT_TICKS)) begin
                        result_now   = 1'b1;
                        rsp_cause_in = CAUSE_TIMEOUT;
                     end
                  end
                  default: begin
                  end
               endcase
               if (result_now) begin
                  rsp_steer_in = cfg.steer_center_us;
                  rsp_thr_in   = cfg.thr_neutral_us;
               end
            end
         end
         ST_CLAMP: begin
            // Clamp the value and pick the span on its side of center
            if (v_ext > lim_pos) begin
               vc_in = lim_pos[VALUE_W-1:0];
            end else if (v_ext < lim_neg) begin
               vc_in = lim_neg[VALUE_W-1:0];
            end else begin
               vc_in = sel_v;
            end
            if (sel_v[VALUE_W-1]) begin
               span_in = $signed({1'b0, sel_mid}) - $signed({1'b0, sel_lo});
            end else begin
               span_in = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_mid});
            end
            // Zero limit gives the center width directly
            if (sel_m == '0) begin
               if (chan_ff) begin
                  thr_in = sel_mid;
               end else begin
                  steer_in = sel_mid;
                  chan_in  = 1'b1;
               end
            end
         end
         ST_MUL0: begin
            cmd.op    = ARITH_MUL_LOAD;
            cmd.mul_a = $signed({1'b0, sel_m});
            cmd.mul_b = $signed({1'b0, sel_mid});
         end
         ST_MUL1: begin
            cmd.op = ARITH_MUL_ACC;
            cnt_in = '0;
         end
         ST_DIV: begin
            cmd.op = ARITH_DIV_STEP;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         ST_STORE: begin
            if (chan_ff) begin
               thr_in = quotient;
            end else begin
               steer_in = quotient;
               chan_in  = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               result_now   = 1'b1;
               rsp_steer_in = steer_ff;
               rsp_thr_in   = thr_ff;
               rsp_cause_in = CAUSE_MAPPED;
            end
         end
         default: begin
         end
      endcase

      // Hold the result until taken
      if (result_now) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= 1'b0;
         cnt_ff       <= '0;
         stop_ff      <= 1'b0;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         cnt_ff       <= cnt_in;
         stop_ff      <= stop_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff     <= angle_in;
      speed_ff     <= speed_in;
      vc_ff        <= vc_in;
      span_ff      <= span_in;
      steer_ff     <= steer_in;
      thr_ff       <= thr_in;
      rsp_steer_ff <= rsp_steer_in;
      rsp_thr_ff   <= rsp_thr_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.steer_pulse_us    = rsp_steer_ff;
   assign rsp_chan.throttle_pulse_us = rsp_thr_ff;
   assign rsp_chan.cause             = rsp_cause_ff;

endmodule
